// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the deframer RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/swpd_pkg.sv =====
// ----------------------------------------------------------------------------
// swpd_pkg
// Types and constants for the sync word packet deframer.
// ----------------------------------------------------------------------------
package swpd_pkg;

    localparam int PHASE_W = 4;

    localparam logic [PHASE_W-1:0] PH_HUNT_HI = 4'd0;
    localparam logic [PHASE_W-1:0] PH_HUNT_LO = 4'd1;
    localparam logic [PHASE_W-1:0] PH_ADDR    = 4'd2;
    localparam logic [PHASE_W-1:0] PH_TYPE    = 4'd3;
    localparam logic [PHASE_W-1:0] PH_LEN_HI  = 4'd4;
    localparam logic [PHASE_W-1:0] PH_LEN_LO  = 4'd5;
    localparam logic [PHASE_W-1:0] PH_PAYLOAD = 4'd6;
    localparam logic [PHASE_W-1:0] PH_SUM_HI  = 4'd7;
    localparam logic [PHASE_W-1:0] PH_SUM_LO  = 4'd8;

    localparam logic [15:0] SYNC_WORD_RESET = 16'hEF01;
    localparam logic [15:0] ADDR_BYTES      = 16'd4;
    localparam logic [15:0] SUM_BYTES       = 16'd2;

    typedef struct packed {
        logic [15:0] computed_sum;
        logic [15:0] received_sum;
        logic [15:0] frame_length;
        logic [7:0]  packet_kind;
        logic [31:0] frame_address;
        logic [7:0]  payload_byte;
        logic        length_error;
        logic        frame_end;
        logic        last_payload;
        logic        is_payload;
    } swpd_result_t;

endpackage

// ===== hdl/sync_word_packet_deframer.sv =====
// ----------------------------------------------------------------------------
// sync_word_packet_deframer
// Sync word hunt, header parse, payload stream and additive checksum.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one received byte per request in tdata[7:0].
//   m_axis carries one result per payload byte and one per frame end;
//   tuser says which, tlast marks the frame's last payload byte.
//   Header bytes, sync bytes and the first checksum byte give no result.
//   cfg_we/cfg_wdata load the sync word (high byte sent first); write it
//   only while the block is idle.
// Timing:
//   One byte accepted per cycle, sustained while m_axis is not stalled. A
//   byte is held in an input register and parsed by the state machine; when
//   the pipe advances, its result lands in the output register and
//   m_axis_tvalid rises.
// Reset:
//   aresetn (synchronous, active low) empties both registers, returns the
//   parser to the hunt and reloads the sync word with 0xEF01.
// Stall:
//   When m_axis_tready is low with a result waiting, the pipe freezes;
//   s_axis_tready drops once the input register holds a byte. No byte or
//   result is lost.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sync_word_packet_deframer
    import swpd_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,

    input  logic         cfg_we,
    input  logic [15:0]  cfg_wdata,      // sync_word

    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] rx_byte

    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [7:0] payload_byte, [39:8] frame_address, [47:40] packet_kind,
    // [63:48] frame_length, [79:64] received_sum, [95:80] computed_sum
    output logic [95:0]  m_axis_tdata,
    output logic         m_axis_tlast,   // last_payload
    // [0] is_payload, [1] frame_end, [2] length_error
    output logic [2:0]   m_axis_tuser
);

    logic [15:0]  sync_reg;
    logic         in_valid_reg;
    logic [7:0]   in_byte_reg;
    logic         out_valid_reg;
    swpd_result_t out_reg;

    logic         advance;
    logic         step;
    logic         res_valid;
    swpd_result_t res;

    assign advance       = !out_valid_reg || m_axis_tready;
    assign step          = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_reg <= SYNC_WORD_RESET;
        end else if (cfg_we) begin
            sync_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            in_byte_reg <= s_axis_tdata;
        end
    end

    swpd_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .rx_byte   (in_byte_reg),
        .sync_word (sync_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= step && res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && step && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_reg.computed_sum, out_reg.received_sum, out_reg.frame_length,
                            out_reg.packet_kind, out_reg.frame_address, out_reg.payload_byte};
    assign m_axis_tlast  = out_reg.last_payload;
    assign m_axis_tuser  = {out_reg.length_error, out_reg.frame_end, out_reg.is_payload};

    `ASSERT_SAME(a_kind_onehot, aclk, aresetn, out_valid_reg,
        $onehot({out_reg.is_payload, out_reg.frame_end}), "result is not exactly one kind")
    `ASSERT_SAME(a_last_is_payload, aclk, aresetn, out_valid_reg && out_reg.last_payload,
        out_reg.is_payload, "last flag on a non-payload result")

endmodule

// ===== hdl/swpd_parser.sv =====
// ----------------------------------------------------------------------------
// swpd_parser
// Frame state machine: one received byte per step, optional result out.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module swpd_parser
    import swpd_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         step,
    input  logic [7:0]   rx_byte,
    input  logic [15:0]  sync_word,
    output logic         res_valid,
    output swpd_result_t res
);

    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [15:0] count_reg, count_next;
    logic [31:0] addr_reg, addr_next;
    logic [7:0]  type_reg, type_next;
    logic [15:0] len_reg, len_next;
    logic [15:0] sum_reg, sum_next;
    logic [7:0]  sum_hi_reg, sum_hi_next;

    logic [7:0]  sync_hi, sync_lo;
    logic [15:0] len_full;
    logic [15:0] count_inc, count_dec;
    logic        len_short;

    assign sync_hi   = sync_word[15:8];
    assign sync_lo   = sync_word[7:0];
    assign len_full  = {len_reg[15:8], rx_byte};
    assign count_inc = count_reg + 16'd1;
    assign count_dec = count_reg - 16'd1;
    assign len_short = (len_reg < SUM_BYTES);

    always_comb begin
        phase_next  = phase_reg;
        count_next  = count_reg;
        addr_next   = addr_reg;
        type_next   = type_reg;
        len_next    = len_reg;
        sum_next    = sum_reg;
        sum_hi_next = sum_hi_reg;
        res_valid   = 1'b0;
        res         = '0;
        case (phase_reg)
            PH_HUNT_LO: begin
                if (rx_byte == sync_lo) begin
                    phase_next = PH_ADDR;
                    count_next = '0;
                    addr_next  = '0;
                end else if (rx_byte != sync_hi) begin
                    phase_next = PH_HUNT_HI;
                end
            end
            PH_ADDR: begin
                addr_next  = {addr_reg[23:0], rx_byte};
                count_next = count_inc;
                if (count_inc >= ADDR_BYTES) begin
                    phase_next = PH_TYPE;
                end
            end
            PH_TYPE: begin
                type_next  = rx_byte;
                phase_next = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                len_next   = {rx_byte, 8'h00};
                phase_next = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                len_next = len_full;
                sum_next = {8'h00, len_full[15:8]} + {8'h00, rx_byte} + {8'h00, type_reg};
                if (len_full < SUM_BYTES) begin
                    count_next = '0;
                    phase_next = PH_SUM_HI;
                end else begin
                    count_next = len_full - SUM_BYTES;
                    phase_next = (len_full == SUM_BYTES) ? PH_SUM_HI : PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                sum_next         = sum_reg + {8'h00, rx_byte};
                count_next       = count_dec;
                res_valid        = 1'b1;
                res.payload_byte = rx_byte;
                res.is_payload   = 1'b1;
                res.last_payload = (count_dec == 16'd0);
                if (count_dec == 16'd0) begin
                    phase_next = PH_SUM_HI;
                end
            end
            PH_SUM_HI: begin
                sum_hi_next = rx_byte;
                phase_next  = PH_SUM_LO;
            end
            PH_SUM_LO: begin
                res_valid         = 1'b1;
                res.frame_end     = 1'b1;
                res.frame_address = addr_reg;
                res.packet_kind   = type_reg;
                res.frame_length  = len_reg;
                res.received_sum  = {sum_hi_reg, rx_byte};
                res.computed_sum  = sum_reg;
                res.length_error  = len_short;
                phase_next        = PH_HUNT_HI;
            end
            default: begin
                // hunting for the first sync byte, also recovers odd codes
                phase_next = (rx_byte == sync_hi) ? PH_HUNT_LO : PH_HUNT_HI;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_HUNT_HI;
            count_reg  <= '0;
            addr_reg   <= '0;
            type_reg   <= '0;
            len_reg    <= '0;
            sum_reg    <= '0;
            sum_hi_reg <= '0;
        end else if (step) begin
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            addr_reg   <= addr_next;
            type_reg   <= type_next;
            len_reg    <= len_next;
            sum_reg    <= sum_next;
            sum_hi_reg <= sum_hi_next;
        end
    end

    `ASSERT_SAME(a_payload_count, aclk, aresetn, phase_reg == PH_PAYLOAD, count_reg != 16'd0,
        "payload phase with no bytes due")
    `ASSERT_NEXT(a_end_to_hunt, aclk, aresetn, step && res_valid && res.frame_end,
        phase_reg == PH_HUNT_HI, "frame end did not return to hunt")

endmodule
